FILE: rtl/core/stack_machine_execute_unit_assert.svh
// assertion macros shared by the checker of the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define SMEU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smeu check failed");

// next-cycle implication
`define SMEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smeu check failed");

`endif

FILE: rtl/core/smeu_pkg.sv
// types and constants of the stack machine execute unit
package smeu_pkg;

  localparam int KIND_W   = 5;
  localparam int WORD_W   = 32;
  localparam int OFFS_W   = 5;
  localparam int VIDX_W   = 4;
  localparam int ERR_W    = 2;
  localparam int FRAC_W   = 16;
  localparam int NUM_W    = WORD_W + FRAC_W;
  localparam int DIV_STEPS = NUM_W / 2;

  localparam logic [WORD_W-1:0] Q_ONE = 32'h0001_0000;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH = 5'd0,
    OP_ADD  = 5'd1,
    OP_SUB  = 5'd2,
    OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,
    OP_LT   = 5'd5,
    OP_LTE  = 5'd6,
    OP_GT   = 5'd7,
    OP_GTE  = 5'd8,
    OP_EQ   = 5'd9,
    OP_NE   = 5'd10,
    OP_NOT  = 5'd11,
    OP_AND  = 5'd12,
    OP_OR   = 5'd13,
    OP_DUP  = 5'd14,
    OP_POP  = 5'd15,
    OP_GET  = 5'd16,
    OP_SET  = 5'd17,
    OP_JMP  = 5'd18,
    OP_CJMP = 5'd19
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIVZ  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL,
    ST_DIV
  } state_t;

endpackage

FILE: rtl/core/smeu_cmd_if.sv
// instruction channel of the stack machine execute unit
interface smeu_cmd_if;
  import smeu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [WORD_W-1:0] immediate;
  logic signed [OFFS_W-1:0] jump_offset;
  logic [VIDX_W-1:0]        var_index;

  modport source (output valid, kind, immediate, jump_offset, var_index, input ready);
  modport sink (input valid, kind, immediate, jump_offset, var_index, output ready);
endinterface

FILE: rtl/core/smeu_res_if.sv
// result channel of the stack machine execute unit
interface smeu_res_if #(parameter int DEPTH_W = 8);
  import smeu_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [OFFS_W-1:0] pc_step;
  logic signed [WORD_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic [ERR_W-1:0]         error;

  modport source (output valid, pc_step, top_value, depth, error, input ready);
  modport sink (input valid, pc_step, top_value, depth, error, output ready);
endinterface

FILE: rtl/core/smeu_ram.sv
// generic single-port-write ram with registered read
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/smeu_div.sv
// iterative unsigned divider, two quotient bits per cycle
module smeu_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [smeu_pkg::NUM_W-1:0]  num,
  input  logic [smeu_pkg::WORD_W-1:0] den,
  output logic                        done,
  output logic [smeu_pkg::NUM_W-1:0]  quot
);
  import smeu_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [WORD_W:0]    rem, rem_next;
  logic [NUM_W-1:0]   quo_next;
  logic [WORD_W-1:0]  den_r;
  logic [CNT_W-1:0]   cnt;
  logic               run;

  always_comb begin
    rem_next = rem;
    quo_next = quot;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[WORD_W-1:0], quo_next[NUM_W-1]};
      quo_next = {quo_next[NUM_W-2:0], 1'b0};
      if (rem_next >= {1'b0, den_r}) begin
        rem_next    = rem_next - {1'b0, den_r};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quot  <= num;
      den_r <= den;
    end else if (run) begin
      rem  <= rem_next;
      quot <= quo_next;
    end
  end
endmodule

FILE: rtl/core/stack_machine_execute_unit.sv
// stack machine execute unit: top level
// each instruction runs in ST_EXEC; mul goes on in ST_MUL, div in ST_DIV
// until the divider is done. one at a time: the next is taken in the cycle
// its result is taken (res.ready high) or once the result channel is empty
// stack below the top lives in a ram read ahead of use; the top is a register
// synchronous reset empties the stack and clears the variables to zero
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH = 128,
  parameter int VAR_COUNT   = 5
) (
  input logic        clk,
  input logic        rst,
  smeu_cmd_if.sink   cmd,
  smeu_res_if.source res
);
  import smeu_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int VW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  state_t state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] tos, tos_next;
  logic [WORD_W-1:0] vars [VAR_COUNT];
  logic              var_we;
  logic [KIND_W-1:0] op;
  logic [WORD_W-1:0] imm;
  logic [OFFS_W-1:0] offs;
  logic [VIDX_W-1:0] vidx;
  logic signed [63:0] prod;
  logic              div_neg;

  logic              accept, finish;
  logic [OFFS_W-1:0] f_step;
  err_t              f_err;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              empty, under2, full, var_ok;
  logic [WORD_W-1:0] below, var_val, alu;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_quot;
  logic [WORD_W-1:0] mag_a, mag_b;
  logic signed [63:0] mul_sh;
  logic [WORD_W-1:0] mul_res, div_res;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign empty  = (count == '0);
  assign under2 = (count < CW'(2));
  assign full   = (count == CW'(STACK_DEPTH));
  assign var_ok = (vidx < VIDX_W'(VAR_COUNT));
  assign var_val = var_ok ? vars[vidx[VW-1:0]] : '0;
  assign accept = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE) && (!res.valid || res.ready);

  smeu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (below)
  );

  assign mag_a = below[WORD_W-1] ? (~below + 1'b1) : below;
  assign mag_b = tos[WORD_W-1] ? (~tos + 1'b1) : tos;

  smeu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({mag_a, {FRAC_W{1'b0}}}),
    .den   (mag_b),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    case (op)
      OP_ADD:  alu = below + tos;
      OP_SUB:  alu = below - tos;
      OP_LT:   alu = ($signed(below) < $signed(tos)) ? Q_ONE : '0;
      OP_LTE:  alu = ($signed(below) <= $signed(tos)) ? Q_ONE : '0;
      OP_GT:   alu = ($signed(below) > $signed(tos)) ? Q_ONE : '0;
      OP_GTE:  alu = ($signed(below) >= $signed(tos)) ? Q_ONE : '0;
      OP_EQ:   alu = (below == tos) ? Q_ONE : '0;
      OP_NE:   alu = (below != tos) ? Q_ONE : '0;
      OP_AND:  alu = (below != '0 && tos != '0) ? Q_ONE : '0;
      default: alu = (below != '0 || tos != '0) ? Q_ONE : '0;
    endcase
  end

  always_comb begin
    mul_sh = prod >>> FRAC_W;
    if (mul_sh > SAT_HI) begin
      mul_res = 32'h7FFF_FFFF;
    end else if (mul_sh < SAT_LO) begin
      mul_res = 32'h8000_0000;
    end else begin
      mul_res = mul_sh[WORD_W-1:0];
    end
    if (!div_neg) begin
      div_res = (div_quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quot[WORD_W-1:0];
    end else begin
      div_res = (div_quot > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                   : (~div_quot[WORD_W-1:0] + 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    tos_next   = tos;
    ram_we     = 1'b0;
    ram_wdata  = tos;
    var_we     = 1'b0;
    finish     = 1'b0;
    f_step     = OFFS_W'(1);
    f_err      = ERR_OK;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        finish     = 1'b1;
        state_next = ST_IDLE;
        case (op)
          OP_PUSH: begin
            if (full) begin
              f_err = ERR_OVER;
            end else begin
              ram_we     = !empty;
              tos_next   = imm;
              count_next = count + 1'b1;
            end
          end
          OP_ADD, OP_SUB, OP_LT, OP_LTE, OP_GT, OP_GTE, OP_EQ, OP_NE, OP_AND, OP_OR: begin
            if (under2) begin
              f_err = ERR_UNDER;
            end else begin
              tos_next   = alu;
              count_next = cnt_m1;
            end
          end
          OP_MUL: begin
            if (under2) begin
              f_err = ERR_UNDER;
            end else begin
              finish     = 1'b0;
              state_next = ST_MUL;
            end
          end
          OP_DIV: begin
            if (under2) begin
              f_err = ERR_UNDER;
            end else if (tos == '0) begin
              f_err = ERR_DIVZ;
            end else begin
              finish     = 1'b0;
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
          OP_NOT: begin
            if (empty) begin
              f_err = ERR_UNDER;
            end else begin
              tos_next = (tos == '0) ? Q_ONE : '0;
            end
          end
          OP_DUP: begin
            if (empty) begin
              f_err = ERR_UNDER;
            end else if (full) begin
              f_err = ERR_OVER;
            end else begin
              ram_we     = 1'b1;
              count_next = count + 1'b1;
            end
          end
          OP_POP: begin
            if (empty) begin
              f_err = ERR_UNDER;
            end else begin
              tos_next   = below;
              count_next = cnt_m1;
            end
          end
          OP_GET: begin
            if (var_ok) begin
              if (full) begin
                f_err = ERR_OVER;
              end else begin
                ram_we     = !empty;
                tos_next   = var_val;
                count_next = count + 1'b1;
              end
            end
          end
          OP_SET: begin
            if (var_ok) begin
              if (empty) begin
                f_err = ERR_UNDER;
              end else begin
                var_we     = 1'b1;
                tos_next   = below;
                count_next = cnt_m1;
              end
            end
          end
          OP_JMP: begin
            f_step = offs;
          end
          OP_CJMP: begin
            if (!empty) begin
              tos_next   = below;
              count_next = cnt_m1;
              if (tos != '0) begin
                f_step = offs;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_MUL: begin
        finish     = 1'b1;
        tos_next   = mul_res;
        count_next = cnt_m1;
        state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) begin
          finish     = 1'b1;
          tos_next   = div_res;
          count_next = cnt_m1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res.valid <= 1'b0;
      for (int i = 0; i < VAR_COUNT; i++) begin
        vars[i] <= '0;
      end
    end else begin
      state <= state_next;
      count <= count_next;
      if (var_we) begin
        vars[vidx[VW-1:0]] <= tos;
      end
      if (finish) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (accept) begin
      op   <= cmd.kind;
      imm  <= cmd.immediate;
      offs <= cmd.jump_offset;
      vidx <= cmd.var_index;
    end
    if (state == ST_EXEC) begin
      prod    <= $signed(below) * $signed(tos);
      div_neg <= below[WORD_W-1] ^ tos[WORD_W-1];
    end
    if (finish) begin
      res.pc_step   <= f_step;
      res.top_value <= (count_next == '0) ? '0 : tos_next;
      res.depth     <= count_next;
      res.error     <= f_err;
    end
  end
endmodule

FILE: rtl/core/smeu_checker.sv
// port-level checker of the stack machine execute unit, with its bind
module smeu_checker #(
  parameter int DEPTH_W = 8
) (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [4:0]         res_pc_step,
  input logic [31:0]        res_top_value,
  input logic [DEPTH_W-1:0] res_depth,
  input logic [1:0]         res_error
);
  import smeu_pkg::*;

`include "stack_machine_execute_unit_assert.svh"

  `SMEU_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_top_value) && $stable(res_depth))
  `SMEU_ASSERT_NOW(a_err_step, res_valid && res_error != ERR_OK, res_pc_step == 5'd1)
  `SMEU_ASSERT_NOW(a_empty_top, res_valid && res_depth == '0, res_top_value == '0)
  `SMEU_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready)
endmodule

bind stack_machine_execute_unit smeu_checker #(
  .DEPTH_W ($clog2(STACK_DEPTH + 1))
) u_smeu_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_pc_step   (res.pc_step),
  .res_top_value (res.top_value),
  .res_depth     (res.depth),
  .res_error     (res.error)
);

FILE: dv/stack_machine_execute_unit_checker.sv
// checker: predicts the stack machine results and compares them with the result channel
module stack_machine_execute_unit_checker
  import smeu_pkg::*;
#(
  parameter int STACK_DEPTH = 128,
  parameter int VAR_COUNT   = 5
) (
  input  logic  clk,
  input  logic  rst,
  smeu_cmd_if   cmd,
  smeu_res_if   res,
  output int    mismatches,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [OFFS_W-1:0] pc_step;
    logic signed [WORD_W-1:0] top_value;
    logic [7:0]               depth;
    logic [ERR_W-1:0]         error;
  } outcome_t;

  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_cnt;
  logic [WORD_W-1:0] var_file [VAR_COUNT];
  outcome_t          expected_q [$];

  function automatic logic [WORD_W-1:0] sat32(logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] flag(bit c);
    return c ? Q_ONE : '0;
  endfunction

  function automatic outcome_t execute(logic [KIND_W-1:0] k, logic [WORD_W-1:0] imm,
                                       logic [OFFS_W-1:0] offs, logic [VIDX_W-1:0] vidx);
    outcome_t o;
    logic [WORD_W-1:0] a, b, r;
    logic signed [63:0] sa, sb;
    int unsigned n;
    n = stack_cnt;
    o.pc_step = 1;
    o.error = ERR_OK;
    r = '0;
    case (k)
      OP_PUSH: begin
        if (n >= STACK_DEPTH) o.error = ERR_OVER;
        else begin
          stack_mem[n] = imm;
          stack_cnt = n + 1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_LTE, OP_GT, OP_GTE, OP_EQ, OP_NE,
      OP_AND, OP_OR: begin
        if (n < 2) o.error = ERR_UNDER;
        else begin
          a = stack_mem[n-2];
          b = stack_mem[n-1];
          sa = 64'(signed'(a));
          sb = 64'(signed'(b));
          case (k)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = sat32((sa * sb) >>> FRAC_W);
            OP_DIV: begin
              if (b == '0) o.error = ERR_DIVZ;
              else r = sat32((sa * 64'sd65536) / sb);
            end
            OP_LT:  r = flag(sa < sb);
            OP_LTE: r = flag(sa <= sb);
            OP_GT:  r = flag(sa > sb);
            OP_GTE: r = flag(sa >= sb);
            OP_EQ:  r = flag(a == b);
            OP_NE:  r = flag(a != b);
            OP_AND: r = flag(a != '0 && b != '0);
            default: r = flag(a != '0 || b != '0);
          endcase
          if (o.error == ERR_OK) begin
            stack_mem[n-2] = r;
            stack_cnt = n - 1;
          end
        end
      end
      OP_NOT: begin
        if (n == 0) o.error = ERR_UNDER;
        else stack_mem[n-1] = flag(stack_mem[n-1] == '0);
      end
      OP_DUP: begin
        if (n == 0) o.error = ERR_UNDER;
        else if (n >= STACK_DEPTH) o.error = ERR_OVER;
        else begin
          stack_mem[n] = stack_mem[n-1];
          stack_cnt = n + 1;
        end
      end
      OP_POP: begin
        if (n == 0) o.error = ERR_UNDER;
        else stack_cnt = n - 1;
      end
      OP_GET: begin
        if (vidx < VAR_COUNT) begin
          if (n >= STACK_DEPTH) o.error = ERR_OVER;
          else begin
            stack_mem[n] = var_file[vidx];
            stack_cnt = n + 1;
          end
        end
      end
      OP_SET: begin
        if (vidx < VAR_COUNT) begin
          if (n == 0) o.error = ERR_UNDER;
          else begin
            var_file[vidx] = stack_mem[n-1];
            stack_cnt = n - 1;
          end
        end
      end
      OP_JMP: o.pc_step = offs;
      OP_CJMP: begin
        if (n > 0) begin
          stack_cnt = n - 1;
          if (stack_mem[n-1] != '0) o.pc_step = offs;
        end
      end
      default: ;
    endcase
    o.top_value = stack_cnt ? stack_mem[stack_cnt-1] : '0;
    o.depth = 8'(stack_cnt);
    return o;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    outcome_t w;
    if (rst) begin
      stack_cnt = 0;
      foreach (var_file[i]) var_file[i] = '0;
      expected_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) report("unexpected transaction", 0, 0);
        else begin
          w = expected_q.pop_front();
          if (res.pc_step !== w.pc_step) report("pc_step", 64'(res.pc_step), 64'(w.pc_step));
          if (res.top_value !== w.top_value)
            report("top_value", 64'(res.top_value), 64'(w.top_value));
          if (res.depth !== w.depth) report("depth", 64'(res.depth), 64'(w.depth));
          if (res.error !== w.error) report("error", 64'(res.error), 64'(w.error));
        end
      end
      if (cmd.valid && cmd.ready)
        expected_q.push_back(execute(cmd.kind, cmd.immediate, cmd.jump_offset, cmd.var_index));
    end
    pending = expected_q.size();
  end

  initial begin
    mismatches = 0;
    pending = 0;
    stack_cnt = 0;
  end
endmodule

FILE: dv/tb_stack_machine_execute_unit.sv
// testbench top: stimulus, idling and verdict for the stack machine execute unit
module tb_stack_machine_execute_unit;
  import smeu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   quiet_cycles;
  bit   no_gaps;
  bit   finished;

  smeu_cmd_if cmd_ch ();
  smeu_res_if res_ch ();

  stack_machine_execute_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  stack_machine_execute_unit_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic issue(logic [KIND_W-1:0] k, logic [WORD_W-1:0] imm = '0,
                       logic [OFFS_W-1:0] offs = 1, logic [VIDX_W-1:0] vidx = '0);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= k;
    cmd_ch.immediate   <= imm;
    cmd_ch.jump_offset <= offs;
    cmd_ch.var_index   <= vidx;
    do @(negedge clk); while (!cmd_ch.ready);
    @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return Q_ONE;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return WORD_W'($urandom_range(0, 4)) << FRAC_W;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_item();
    int r;
    logic [WORD_W-1:0] rimm;
    logic [OFFS_W-1:0] roffs;
    logic [VIDX_W-1:0] rvidx;
    r = $urandom_range(0, 99);
    rimm = $urandom();
    roffs = OFFS_W'($urandom());
    rvidx = VIDX_W'($urandom());
    if (r < 30) issue(OP_PUSH, pick_value(), roffs, rvidx);
    else if (r < 62) issue(kind_t'($urandom_range(OP_ADD, OP_OR)), rimm, roffs, rvidx);
    else if (r < 68) issue(OP_DUP, rimm, roffs, rvidx);
    else if (r < 73) issue(OP_POP, rimm, roffs, rvidx);
    else if (r < 81) issue(OP_GET, rimm, roffs, rvidx);
    else if (r < 88) issue(OP_SET, rimm, roffs, rvidx);
    else if (r < 92) issue(OP_JMP, rimm, roffs, rvidx);
    else if (r < 97) issue(OP_CJMP, rimm, roffs, rvidx);
    else issue(KIND_W'($urandom_range(OP_CJMP + 1, 31)), rimm, roffs, rvidx);
  endtask

  // result side stalls
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(negedge clk); while (!res_ch.valid);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (!finished && quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_stack_machine_execute_unit failed");
      $finish;
    end
  end

  initial begin
    finished = 1'b0;
    no_gaps = 1'b0;
    quiet_cycles = 0;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.kind <= OP_PUSH;
    cmd_ch.immediate <= '0;
    cmd_ch.jump_offset <= '0;
    cmd_ch.var_index <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stack cases, then mul, div, each binary kind and an unknown kind
    issue(OP_ADD);
    issue(OP_NOT);
    issue(OP_POP);
    issue(OP_SET, '0, 1, 4'd0);
    issue(OP_CJMP, '0, 5'sd7);
    issue(OP_JMP, '0, 5'b10000);
    issue(OP_JMP, '0, '0);
    issue(OP_GET, '0, 1, 4'd4);
    issue(OP_GET, '0, 1, 4'd15);
    issue(OP_PUSH, 32'h7FFF_FFFF);
    issue(OP_DUP);
    issue(OP_MUL);
    issue(OP_PUSH, 32'h8000_0000);
    issue(OP_DIV);
    issue(OP_PUSH, '0);
    issue(OP_DIV);
    issue(OP_SET, '0, 1, 4'd4);
    issue(OP_SET, '0, 1, 4'd9);
    issue(OP_PUSH, Q_ONE);
    issue(OP_CJMP, '0, 5'sd15);
    for (int k = OP_ADD; k <= OP_OR; k++) begin
      issue(OP_PUSH, pick_value());
      issue(OP_PUSH, pick_value());
      issue(KIND_W'(k));
    end
    issue(KIND_W'(31));

    for (int i = 0; i < 250; i++) begin
      if (i % 60 == 0) no_gaps = ~no_gaps;
      random_item();
    end

    // hold off until the unit has drained
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);

    // fill past the top, then pop and set with random items mixed in
    for (int i = 0; i < 132; i++) issue(OP_PUSH, pick_value());
    issue(OP_DUP);
    issue(OP_GET, '0, 1, 4'd2);
    for (int i = 0; i < 134; i++) begin
      if ($urandom_range(0, 3) == 0) random_item();
      else issue(kind_t'($urandom_range(0, 1) ? OP_POP : OP_SET), '0, 1,
                 VIDX_W'($urandom()));
    end

    for (int i = 0; i < 200; i++) begin
      if (i % 50 == 0) no_gaps = ~no_gaps;
      random_item();
    end
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    finished = 1'b1;
    if (mismatches == 0)
      $display("tb_stack_machine_execute_unit passed");
    else
      $display("tb_stack_machine_execute_unit failed");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/smeu_pkg.sv
rtl/core/smeu_cmd_if.sv
rtl/core/smeu_res_if.sv
rtl/core/smeu_ram.sv
rtl/core/smeu_div.sv
rtl/core/stack_machine_execute_unit.sv
rtl/core/smeu_checker.sv
dv/stack_machine_execute_unit_checker.sv
dv/tb_stack_machine_execute_unit.sv
